@@ hdl/scba_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Size-class block allocator package
// Shared widths, operation and status codes, and the command word that the
// front end hands to the back end through the queue.
// ----------------------------------------------------------------------------
package scba_pkg;

    localparam int unsigned HANDLE_W     = 10;
    localparam int unsigned HANDLE_SPACE = 1 << HANDLE_W;
    localparam int unsigned CLASS_MAX    = 8;
    localparam int unsigned CLASS_W      = 3;
    localparam int unsigned CLS_W        = 11;
    localparam int unsigned REQ_W        = 20;
    localparam int unsigned STATUS_W     = 3;
    localparam int unsigned LINK_W       = HANDLE_W + 1;
    localparam int unsigned QUEUE_DEPTH  = 2;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_TOO_LARGE,
        OP_NOT_POOL
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_GRANTED   = 3'd0,
        ST_TOO_LARGE = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_FREED     = 3'd3,
        ST_NOT_POOL  = 3'd4
    } status_t;

    typedef struct packed {
        op_t                 op;
        logic [CLASS_W-1:0]  cls;
        logic [HANDLE_W-1:0] handle;
        logic [CLS_W-1:0]    bytes;
    } cmd_t;

endpackage

@@ hdl/scba_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module scba_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/scba_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Command queue
// Short register FIFO between the classifying front end and the back end.
// ----------------------------------------------------------------------------
module scba_queue
    import scba_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  cmd_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output cmd_t pop_data
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign push_ready = (cnt_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hdl/scba_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request front end
// Accepts request transactions and classifies them: size class of an
// allocation, owning class of a freed handle, and the rounded block size.
// ----------------------------------------------------------------------------
module scba_front
    import scba_pkg::*;
#(
    parameter int unsigned                       CLASS_COUNT    = 8,
    parameter int unsigned                       SMALLEST_BLOCK = 8,
    parameter logic [CLASS_MAX*CLS_W-1:0]        CLS_BASE       = '0,
    parameter logic [CLASS_MAX*CLS_W-1:0]        CLS_BLOCKS     = '0
) (
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_func,
    input  logic [REQ_W-1:0]    s_request_bytes,
    input  logic [HANDLE_W-1:0] s_block_handle,
    input  logic                init_done,
    output logic                push_valid,
    input  logic                push_ready,
    output cmd_t                push_data
);

    logic               alloc_found, free_found;
    logic [CLASS_W-1:0] alloc_cls, free_cls, sel_cls;
    logic [31:0]        sel_bytes;
    logic [CLS_W-1:0]   base;
    logic [CLS_W-1:0]   blocks;

    assign s_ready    = init_done && push_ready;
    assign push_valid = s_valid && init_done;

    always_comb begin
        alloc_found = 1'b0;
        alloc_cls   = '0;
        free_found  = 1'b0;
        free_cls    = '0;
        base        = '0;
        blocks      = '0;
        for (int c = CLASS_MAX - 1; c >= 0; c--) begin
            if ((c < CLASS_COUNT) &&
                ({12'd0, s_request_bytes} < (32'(SMALLEST_BLOCK) << c))) begin
                alloc_found = 1'b1;
                alloc_cls   = CLASS_W'(c);
            end
        end
        for (int c = CLASS_MAX - 1; c >= 0; c--) begin
            base   = CLS_BASE[c*CLS_W +: CLS_W];
            blocks = CLS_BLOCKS[c*CLS_W +: CLS_W];
            if (({1'b0, s_block_handle} >= base) &&
                ({2'b0, s_block_handle} < ({1'b0, base} + {1'b0, blocks}))) begin
                free_found = 1'b1;
                free_cls   = CLASS_W'(c);
            end
        end
    end

    always_comb begin
        sel_cls   = s_func ? free_cls : alloc_cls;
        sel_bytes = 32'(SMALLEST_BLOCK) << sel_cls;
        push_data.handle = s_block_handle;
        push_data.cls    = sel_cls;
        push_data.bytes  = sel_bytes[CLS_W-1:0];
        if (!s_func) begin
            push_data.op = alloc_found ? OP_ALLOC : OP_TOO_LARGE;
        end else begin
            push_data.op = free_found ? OP_FREE : OP_NOT_POOL;
        end
    end

endmodule

@@ hdl/scba_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Allocator back end
// Holds the class heads and free counts and the link/mark RAM. Pops and
// pushes free lists by a read-modify-write of one RAM entry, and runs the
// link initialisation sweep after reset.
// ----------------------------------------------------------------------------
module scba_back
    import scba_pkg::*;
#(
    parameter logic [CLASS_MAX*CLS_W-1:0] CLS_BASE   = '0,
    parameter logic [CLASS_MAX*CLS_W-1:0] CLS_BLOCKS = '0
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                q_valid,
    output logic                q_ready,
    input  cmd_t                q_data,
    output logic                init_done,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [HANDLE_W-1:0] m_granted_handle,
    output logic [CLASS_W-1:0]  m_size_class,
    output logic [CLS_W-1:0]    m_granted_bytes
);

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_RMW} state_t;

    state_t              state_reg;
    logic [HANDLE_W-1:0] clr_reg;
    cmd_t                cur_reg;
    logic [HANDLE_W-1:0] head_reg  [CLASS_MAX];
    logic [CLS_W-1:0]    count_reg [CLASS_MAX];
    logic                m_valid_reg;
    status_t             m_status_reg;
    logic [HANDLE_W-1:0] m_handle_reg;
    logic [CLASS_W-1:0]  m_class_reg;
    logic [CLS_W-1:0]    m_bytes_reg;

    logic                slot_free, pop;
    logic                result_now;
    logic                ram_we;
    logic [HANDLE_W-1:0] ram_waddr, ram_raddr;
    logic [LINK_W-1:0]   ram_wdata, ram_rdata;
    logic                rd_mark;
    logic [HANDLE_W-1:0] rd_link;

    assign slot_free = !m_valid_reg || m_ready;
    assign pop       = (state_reg == S_IDLE) && q_valid && slot_free;
    assign q_ready   = pop;
    assign init_done = (state_reg != S_CLEAR);
    assign ram_raddr = (q_data.op == OP_ALLOC) ? head_reg[q_data.cls] : q_data.handle;
    assign rd_mark   = ram_rdata[LINK_W-1];
    assign rd_link   = ram_rdata[HANDLE_W-1:0];

    // result register loaded this cycle
    assign result_now = (state_reg == S_RMW) ||
                        (pop && ((q_data.op inside {OP_TOO_LARGE, OP_NOT_POOL}) ||
                                 ((q_data.op == OP_ALLOC) &&
                                  (count_reg[q_data.cls] == '0))));

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = cur_reg.handle;
        ram_wdata = {1'b0, head_reg[cur_reg.cls]};
        case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = {1'b0, clr_reg + 1'b1};
            end
            S_RMW: begin
                if (cur_reg.op == OP_ALLOC) begin
                    ram_we    = 1'b1;
                    ram_wdata = {1'b1, rd_link};
                end else begin
                    ram_we = rd_mark;
                end
            end
            default: ;
        endcase
    end

    scba_ram #(
        .WIDTH (LINK_W),
        .DEPTH (HANDLE_SPACE)
    ) u_link_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int c = 0; c < CLASS_MAX; c++) begin
                head_reg[c]  <= CLS_BASE[c*CLS_W +: HANDLE_W];
                count_reg[c] <= CLS_BLOCKS[c*CLS_W +: CLS_W];
            end
        end else begin
            if (result_now) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == HANDLE_W'(HANDLE_SPACE - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (pop) begin
                        cur_reg.op     <= q_data.op;
                        cur_reg.cls    <= q_data.cls;
                        cur_reg.bytes  <= q_data.bytes;
                        cur_reg.handle <= ram_raddr;
                        case (q_data.op)
                            OP_TOO_LARGE: begin
                                m_status_reg <= ST_TOO_LARGE;
                                m_handle_reg <= '0;
                                m_class_reg  <= '0;
                                m_bytes_reg  <= '0;
                            end
                            OP_NOT_POOL: begin
                                m_status_reg <= ST_NOT_POOL;
                                m_handle_reg <= '0;
                                m_class_reg  <= '0;
                                m_bytes_reg  <= '0;
                            end
                            OP_ALLOC: begin
                                if (count_reg[q_data.cls] == '0) begin
                                    m_status_reg <= ST_EMPTY;
                                    m_handle_reg <= '0;
                                    m_class_reg  <= q_data.cls;
                                    m_bytes_reg  <= q_data.bytes;
                                end else begin
                                    state_reg <= S_RMW;
                                end
                            end
                            default: begin
                                state_reg <= S_RMW;
                            end
                        endcase
                    end
                end
                S_RMW: begin
                    state_reg <= S_IDLE;
                    if (cur_reg.op == OP_ALLOC) begin
                        head_reg[cur_reg.cls]  <= rd_link;
                        count_reg[cur_reg.cls] <= count_reg[cur_reg.cls] - 1'b1;
                        m_status_reg <= ST_GRANTED;
                        m_handle_reg <= cur_reg.handle;
                        m_class_reg  <= cur_reg.cls;
                        m_bytes_reg  <= cur_reg.bytes;
                    end else if (rd_mark) begin
                        head_reg[cur_reg.cls]  <= cur_reg.handle;
                        count_reg[cur_reg.cls] <= count_reg[cur_reg.cls] + 1'b1;
                        m_status_reg <= ST_FREED;
                        m_handle_reg <= '0;
                        m_class_reg  <= cur_reg.cls;
                        m_bytes_reg  <= cur_reg.bytes;
                    end else begin
                        m_status_reg <= ST_NOT_POOL;
                        m_handle_reg <= '0;
                        m_class_reg  <= '0;
                        m_bytes_reg  <= '0;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = m_status_reg;
    assign m_granted_handle = m_handle_reg;
    assign m_size_class     = m_class_reg;
    assign m_granted_bytes  = m_bytes_reg;

    logic [CLS_W-1:0] grant_base, grant_blocks;
    assign grant_base   = CLS_BASE[m_class_reg*CLS_W +: CLS_W];
    assign grant_blocks = CLS_BLOCKS[m_class_reg*CLS_W +: CLS_W];

    a_no_result_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CLEAR) |-> (!m_valid_reg && !pop))
        else $error("result or pop during link initialisation");

    a_slot_empty_in_rmw: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RMW) |-> !m_valid_reg)
        else $error("output register occupied during read-modify-write");

    a_write_only_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we |-> (state_reg != S_IDLE))
        else $error("link RAM written while idle");

    a_grant_in_class: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_status_reg == ST_GRANTED)) |->
        (({1'b0, m_handle_reg} >= grant_base) &&
         ({2'b0, m_handle_reg} < ({1'b0, grant_base} + {1'b0, grant_blocks}))))
        else $error("granted handle outside its class region");

endmodule

@@ hdl/size_class_block_allocator_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Size-class block allocator
// Power-of-two size classes, each a fixed pool with a LIFO free list.
// ----------------------------------------------------------------------------
// After reset the link RAM is initialised by a sweep over all its entries,
// during which s_ready stays low. An allocate or free that touches a free
// list first reads the link/mark RAM entry in the back end, then writes it
// back and updates the class head. Requests answered from classification
// alone (too large, not a pool block, empty class) need no RAM access. A
// two-entry command queue lets the front end accept requests while the back
// end is busy or the result register waits on m_ready.
// ----------------------------------------------------------------------------
module size_class_block_allocator_core
    import scba_pkg::*;
#(
    parameter int unsigned POOL_BYTES     = 4096,
    parameter int unsigned CLASS_COUNT    = 8,
    parameter int unsigned SMALLEST_BLOCK = 8
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_func,
    input  logic [REQ_W-1:0]    s_request_bytes,
    input  logic [HANDLE_W-1:0] s_block_handle,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [HANDLE_W-1:0] m_granted_handle,
    output logic [CLASS_W-1:0]  m_size_class,
    output logic [CLS_W-1:0]    m_granted_bytes
);

    localparam int unsigned RAW_N [CLASS_MAX] = '{
        POOL_BYTES / (SMALLEST_BLOCK << 0),
        (CLASS_COUNT > 1) ? POOL_BYTES / (SMALLEST_BLOCK << 1) : 0,
        (CLASS_COUNT > 2) ? POOL_BYTES / (SMALLEST_BLOCK << 2) : 0,
        (CLASS_COUNT > 3) ? POOL_BYTES / (SMALLEST_BLOCK << 3) : 0,
        (CLASS_COUNT > 4) ? POOL_BYTES / (SMALLEST_BLOCK << 4) : 0,
        (CLASS_COUNT > 5) ? POOL_BYTES / (SMALLEST_BLOCK << 5) : 0,
        (CLASS_COUNT > 6) ? POOL_BYTES / (SMALLEST_BLOCK << 6) : 0,
        (CLASS_COUNT > 7) ? POOL_BYTES / (SMALLEST_BLOCK << 7) : 0
    };

    // global numbering stops at the handle space; later classes are cut short
    function automatic logic [CLASS_MAX*CLS_W-1:0] build_layout(input logic want_base);
        logic [CLASS_MAX*CLS_W-1:0] v;
        int unsigned                base;
        int unsigned                n;
        v    = '0;
        base = 0;
        for (int c = 0; c < CLASS_MAX; c++) begin
            n = RAW_N[c];
            if (n > HANDLE_SPACE - base) begin
                n = HANDLE_SPACE - base;
            end
            v[c*CLS_W +: CLS_W] = want_base ? CLS_W'(base) : CLS_W'(n);
            base = base + n;
        end
        return v;
    endfunction

    localparam logic [CLASS_MAX*CLS_W-1:0] CLS_BASE   = build_layout(1'b1);
    localparam logic [CLASS_MAX*CLS_W-1:0] CLS_BLOCKS = build_layout(1'b0);

    logic init_done;
    logic push_valid, push_ready;
    cmd_t push_data;
    logic pop_valid, pop_ready;
    cmd_t pop_data;

    scba_front #(
        .CLASS_COUNT    (CLASS_COUNT),
        .SMALLEST_BLOCK (SMALLEST_BLOCK),
        .CLS_BASE       (CLS_BASE),
        .CLS_BLOCKS     (CLS_BLOCKS)
    ) u_front (
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_func          (s_func),
        .s_request_bytes (s_request_bytes),
        .s_block_handle  (s_block_handle),
        .init_done       (init_done),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_data       (push_data)
    );

    scba_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    scba_back #(
        .CLS_BASE   (CLS_BASE),
        .CLS_BLOCKS (CLS_BLOCKS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (pop_valid),
        .q_ready          (pop_ready),
        .q_data           (pop_data),
        .init_done        (init_done),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_granted_handle (m_granted_handle),
        .m_size_class     (m_size_class),
        .m_granted_bytes  (m_granted_bytes)
    );

endmodule
